// ----- src/sctlip_pkg.sv -----
// ----------------------------------------------------------------------------
// sctlip_pkg
// Types and constants for the SCT extension leaf index parser.
// ----------------------------------------------------------------------------
package sctlip_pkg;

	localparam int unsigned LEAF_W = 40;

	localparam logic [7:0] EXT_TYPE_LEAF_INDEX = 8'h00;
	localparam logic [2:0] LEAF_INDEX_LEN      = 3'd5;
	localparam logic [2:0] DATA_COUNT_SAT      = 3'd6;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              leaf_found;
		logic [LEAF_W-1:0] leaf_idx;
	} out_result_t;

endpackage

// ----- src/sctlip_chan_if.sv -----
// ----------------------------------------------------------------------------
// sctlip_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sctlip_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/sct_extension_leaf_index_parser.sv -----
// ----------------------------------------------------------------------------
// sct_extension_leaf_index_parser
// Streams SCT extension records and extracts the leaf index extension.
// ----------------------------------------------------------------------------
// Takes one byte transaction per cycle. Each byte is held in an input
// register and parsed by the record state update, and the end-of-stream
// result lands in an output register. The input side stalls only while
// a finished result in the output register has not been taken and the
// held byte ends a stream. State returns to reset after each result.
module sct_extension_leaf_index_parser (
	input  logic                clk,
	input  logic                arst_n,
	sctlip_chan_if.sink         item,
	sctlip_chan_if.source       result
);
	import sctlip_pkg::*;

	// input register
	logic       valid_s1;
	in_item_t   item_s1;

	// parser state
	phase_t            phase_q;
	logic              leaf_type_q;
	logic [15:0]       remaining_q;
	logic [2:0]        data_count_q;
	logic [LEAF_W-1:0] acc_q;
	logic              leaf_seen_q;
	logic [LEAF_W-1:0] leaf_value_q;
	status_t           err_q;

	// output register
	logic        res_valid_q;
	out_result_t res_q;

	logic advance;

	phase_t            phase_d;
	logic              leaf_type_d;
	logic [15:0]       remaining_d;
	logic [2:0]        data_count_d;
	logic [LEAF_W-1:0] acc_d;
	logic              leaf_seen_d;
	logic [LEAF_W-1:0] leaf_value_d;
	status_t           err_d;
	logic              finish;
	logic [15:0]       rem_len;
	status_t           status_d;
	out_result_t       res_d;

	assign advance = valid_s1 && (!item_s1.is_last || !res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_comb begin
		phase_d      = phase_q;
		leaf_type_d  = leaf_type_q;
		remaining_d  = remaining_q;
		data_count_d = data_count_q;
		acc_d        = acc_q;
		leaf_seen_d  = leaf_seen_q;
		leaf_value_d = leaf_value_q;
		err_d        = err_q;
		finish       = 1'b0;
		rem_len      = {remaining_q[15:8], item_s1.data_byte};

		if (item_s1.has_byte && err_q == ST_OK) begin
			case (phase_q)
				PH_TYPE: begin
					leaf_type_d  = (item_s1.data_byte == EXT_TYPE_LEAF_INDEX);
					data_count_d = '0;
					acc_d        = '0;
					phase_d      = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					remaining_d = {item_s1.data_byte, 8'h00};
					phase_d     = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					remaining_d = rem_len;
					phase_d     = PH_DATA;
					finish      = (rem_len == 16'd0);
				end
				PH_DATA: begin
					if (data_count_q < LEAF_INDEX_LEN)
						acc_d = {acc_q[LEAF_W-9:0], item_s1.data_byte};
					if (data_count_q < DATA_COUNT_SAT)
						data_count_d = data_count_q + 3'd1;
					remaining_d = remaining_q - 16'd1;
					finish      = (remaining_q == 16'd1);
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase
		end

		if (finish) begin
			phase_d = PH_TYPE;
			if (leaf_type_d) begin
				if (leaf_seen_q)
					err_d = ST_INVALID;
				else if (data_count_d < LEAF_INDEX_LEN)
					err_d = ST_MALFORMED;
				else if (data_count_d > LEAF_INDEX_LEN)
					err_d = ST_INVALID;
				else begin
					leaf_seen_d  = 1'b1;
					leaf_value_d = acc_d;
				end
			end
		end

		status_d = err_d;
		if (err_d == ST_OK && phase_d != PH_TYPE)
			status_d = ST_MALFORMED;

		res_d.status     = status_d;
		res_d.leaf_found = (status_d == ST_OK) && leaf_seen_d;
		res_d.leaf_idx   = res_d.leaf_found ? leaf_value_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
			item_s1  <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			leaf_type_q  <= 1'b0;
			remaining_q  <= '0;
			data_count_q <= '0;
			acc_q        <= '0;
			leaf_seen_q  <= 1'b0;
			leaf_value_q <= '0;
			err_q        <= ST_OK;
		end else if (advance) begin
			if (item_s1.is_last) begin
				phase_q      <= PH_TYPE;
				leaf_type_q  <= 1'b0;
				remaining_q  <= '0;
				data_count_q <= '0;
				acc_q        <= '0;
				leaf_seen_q  <= 1'b0;
				leaf_value_q <= '0;
				err_q        <= ST_OK;
			end else begin
				phase_q      <= phase_d;
				leaf_type_q  <= leaf_type_d;
				remaining_q  <= remaining_d;
				data_count_q <= data_count_d;
				acc_q        <= acc_d;
				leaf_seen_q  <= leaf_seen_d;
				leaf_value_q <= leaf_value_d;
				err_q        <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last)
			res_q <= res_d;
	end

endmodule
